>>> hdl/brle_pkg.sv
// ----------------------------------------------------------------------------
// brle_pkg
// Shared types and constants of the byte run-length stream decoder.
// ----------------------------------------------------------------------------
package brle_pkg;

  localparam int SIZE_WIDTH_DEF = 32;
  localparam int CFG_WIDTH      = 32;
  localparam int CNT_WIDTH      = 7;

  localparam int           LITERAL_BIT = 7;
  localparam logic [7:0]   COUNT_MASK  = 8'h7F;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EARLY    = 2'd2;
  localparam logic [1:0] ST_SHORT    = 2'd3;

  localparam logic [1:0] NV_NONE = 2'd0;
  localparam logic [1:0] NV_ONE  = 2'd1;
  localparam logic [1:0] NV_TWO  = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LITERAL,
    PH_RUN,
    PH_DISCARD
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } seq_state_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [1:0] valid_bytes;
    logic       last_of_item;
    logic       frame_end;
    logic [1:0] status;
  } out_item_t;

endpackage

>>> hdl/brle_out_stage.sv
// ----------------------------------------------------------------------------
// brle_out_stage
// Result holding register: takes a result when empty or being drained.
// ----------------------------------------------------------------------------
module brle_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  brle_pkg::out_item_t push_data,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output brle_pkg::out_item_t out_data
);
  import brle_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

endmodule

>>> hdl/byte_rle_stream_decoder.sv
// ----------------------------------------------------------------------------
// byte_rle_stream_decoder
// Decodes a literal/run packet byte stream into results of up to two bytes with status.
// ----------------------------------------------------------------------------
// A header byte or a literal byte is taken when the result register is free and
// no run or status result is pending. A run value byte starts the run sequencer,
// which emits at most two bytes per cycle while the single result register is
// free, and nothing when the count is zero. A byte that ends the stream outside
// a run leads to a status result, as does a zero-count run that ends the stream.
// The header room check (one subtract and compare over SIZE_WIDTH bits) and the
// byte counter adder, shared by literal and run updates, set the path between
// registers.
module byte_rle_stream_decoder #(
  parameter int SIZE_WIDTH = brle_pkg::SIZE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [brle_pkg::CFG_WIDTH-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  brle_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output brle_pkg::out_item_t            out_data
);
  import brle_pkg::*;

  seq_state_t           state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [CNT_WIDTH-1:0] pkt_r, pkt_nxt;
  logic [SIZE_WIDTH-1:0] bw_r, bw_nxt;
  logic [1:0]           err_r, err_nxt;
  logic [SIZE_WIDTH-1:0] exp_r, exp_nxt;
  logic [7:0]           run_byte_r, run_byte_nxt;
  logic [CNT_WIDTH-1:0] run_cnt_r, run_cnt_nxt;
  logic                 run_eos_r, run_eos_nxt;
  logic [7:0]           fin_byte_r, fin_byte_nxt;
  logic [1:0]           fin_nv_r, fin_nv_nxt;

  logic                 slot_free;
  logic                 push;
  out_item_t            push_data;
  logic                 accept;
  logic [7:0]           b;
  logic                 eos;
  logic [CNT_WIDTH-1:0] cnt;
  logic [SIZE_WIDTH:0]  diff;
  logic                 no_room;
  logic                 over;
  logic [CNT_WIDTH-1:0] addend;
  logic [SIZE_WIDTH-1:0] bw_sum;
  logic [1:0]           fin_status;
  logic                 run_last;

  brle_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .free      (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign in_ready = (state_r == S_IDLE) && slot_free;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.stream_byte;
  assign eos      = in_data.end_of_stream;
  assign cnt      = CNT_WIDTH'(b & COUNT_MASK);

  // room check: header count against expected minus written, zero if passed
  assign diff    = {1'b0, exp_r} - {1'b0, bw_r};
  assign no_room = diff[SIZE_WIDTH] || (diff[SIZE_WIDTH-1:0] == '0);
  assign over    = no_room ? (cnt != '0)
                           : (SIZE_WIDTH'(cnt) > diff[SIZE_WIDTH-1:0]);

  // shared byte counter adder
  assign addend = (phase_r == PH_LITERAL) ? CNT_WIDTH'(1) : pkt_r;
  assign bw_sum = bw_r + SIZE_WIDTH'(addend);

  always_comb begin
    if (err_r != ST_OK) begin
      fin_status = err_r;
    end else if (phase_r == PH_LITERAL || phase_r == PH_RUN) begin
      fin_status = ST_EARLY;
    end else if (exp_r == '0) begin
      fin_status = ST_OVERFLOW;
    end else if (bw_r != exp_r) begin
      fin_status = ST_SHORT;
    end else begin
      fin_status = ST_OK;
    end
  end

  assign run_last = (run_cnt_r <= CNT_WIDTH'(2));

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    pkt_nxt      = pkt_r;
    bw_nxt       = bw_r;
    err_nxt      = err_r;
    exp_nxt      = exp_r;
    run_byte_nxt = run_byte_r;
    run_cnt_nxt  = run_cnt_r;
    run_eos_nxt  = run_eos_r;
    fin_byte_nxt = fin_byte_r;
    fin_nv_nxt   = fin_nv_r;
    push         = 1'b0;
    push_data    = '0;

    if (cfg_we) begin
      exp_nxt = SIZE_WIDTH'(cfg_wdata);
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          fin_byte_nxt = 8'd0;
          fin_nv_nxt   = NV_NONE;
          case (phase_r)
            PH_HEADER: begin
              if (over) begin
                err_nxt   = ST_OVERFLOW;
                phase_nxt = PH_DISCARD;
              end else if (b[LITERAL_BIT]) begin
                if (cnt != '0) begin
                  phase_nxt = PH_LITERAL;
                  pkt_nxt   = cnt;
                end
              end else begin
                phase_nxt = PH_RUN;
                pkt_nxt   = cnt;
              end
              if (eos) begin
                state_nxt = S_FIN;
              end
            end
            PH_LITERAL: begin
              bw_nxt  = bw_sum;
              pkt_nxt = pkt_r - CNT_WIDTH'(1);
              if (pkt_r == CNT_WIDTH'(1)) begin
                phase_nxt = PH_HEADER;
              end
              if (eos) begin
                fin_byte_nxt = b;
                fin_nv_nxt   = NV_ONE;
                state_nxt    = S_FIN;
              end else begin
                push                   = 1'b1;
                push_data.byte_first   = b;
                push_data.valid_bytes  = NV_ONE;
                push_data.last_of_item = 1'b1;
                push_data.status       = err_r;
              end
            end
            PH_RUN: begin
              run_byte_nxt = b;
              run_cnt_nxt  = pkt_r;
              run_eos_nxt  = eos;
              bw_nxt       = bw_sum;
              pkt_nxt      = '0;
              phase_nxt    = PH_HEADER;
              state_nxt    = S_RUN;
            end
            default: begin
              if (eos) begin
                state_nxt = S_FIN;
              end
            end
          endcase
        end
      end
      S_RUN: begin
        if (run_cnt_r == '0) begin
          // zero run: only an end of stream leaves a result
          state_nxt = run_eos_r ? S_FIN : S_IDLE;
        end else if (slot_free) begin
          push                   = 1'b1;
          push_data.byte_first   = run_byte_r;
          push_data.last_of_item = run_last;
          push_data.frame_end    = run_last && run_eos_r;
          push_data.status       = (run_last && run_eos_r) ? fin_status : err_r;
          if (run_cnt_r >= CNT_WIDTH'(2)) begin
            push_data.byte_second = run_byte_r;
            push_data.valid_bytes = NV_TWO;
            run_cnt_nxt           = run_cnt_r - CNT_WIDTH'(2);
          end else begin
            push_data.valid_bytes = NV_ONE;
            run_cnt_nxt           = '0;
          end
          if (run_last) begin
            state_nxt = S_IDLE;
            if (run_eos_r) begin
              phase_nxt = PH_HEADER;
              pkt_nxt   = '0;
              bw_nxt    = '0;
              err_nxt   = ST_OK;
            end
          end
        end
      end
      S_FIN: begin
        if (slot_free) begin
          push                   = 1'b1;
          push_data.byte_first   = fin_byte_r;
          push_data.valid_bytes  = fin_nv_r;
          push_data.last_of_item = 1'b1;
          push_data.frame_end    = 1'b1;
          push_data.status       = fin_status;
          phase_nxt              = PH_HEADER;
          pkt_nxt                = '0;
          bw_nxt                 = '0;
          err_nxt                = ST_OK;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_HEADER;
      pkt_r   <= '0;
      bw_r    <= '0;
      err_r   <= ST_OK;
      exp_r   <= SIZE_WIDTH'(1);
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      pkt_r   <= pkt_nxt;
      bw_r    <= bw_nxt;
      err_r   <= err_nxt;
      exp_r   <= exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_byte_r <= run_byte_nxt;
    run_cnt_r  <= run_cnt_nxt;
    run_eos_r  <= run_eos_nxt;
    fin_byte_r <= fin_byte_nxt;
    fin_nv_r   <= fin_nv_nxt;
  end

endmodule
